// File: rtl/core/epoch_ms_to_calendar_assert.svh
// assertion macros used by the checker file of the epoch to calendar block
`ifndef EPOCH_MS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_MS_TO_CALENDAR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define EMCAL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define EMCAL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/emcal_pkg.sv
package emcal_pkg;

	// field widths
	localparam int MS_W    = 42;
	localparam int YEAR_W  = 7;
	localparam int MONTH_W = 4;
	localparam int DOM_W   = 5;
	localparam int WD_W    = 3;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int SUB_W   = 10;

	// day split: ms >> 10, then divide by 84375 (86400000 / 1024)
	localparam logic [16:0] DAY_DIV   = 17'd84375;
	localparam logic [15:0] DAY_RECIP = 16'd50903;   // floor(2^32 / 84375)
	localparam logic [15:0] DAY_2000  = 16'd10957;
	localparam logic [15:0] DAY_2100  = 16'd47482;
	localparam logic [15:0] WEEK_OFS  = 16'd5;       // (10957 + 3) mod 7

	// four-year cycle
	localparam logic [10:0] QUAD_DAYS  = 11'd1461;
	localparam logic [10:0] QUAD_RECIP = 11'd1435;   // floor(2^21 / 1461)
	localparam logic [10:0] LEAP_YEAR_DAYS = 11'd366;
	localparam logic [10:0] YEAR_DAYS      = 11'd365;
	localparam logic [10:0] TWO_YEAR_DAYS  = 11'd730;

	// time of day
	localparam logic [17:0] SEC_RECIP   = 18'd134217; // floor(2^24 / 125)
	localparam logic [9:0]  MS_PER_SEC  = 10'd1000;
	localparam logic [15:0] DIV15_RECIP = 16'd34953;  // ceil(2^19 / 15)
	localparam logic [5:0]  SEC_PER_MIN = 6'd60;
	localparam logic [16:0] SUB_RECIP   = 17'd67109;  // ceil(2^23 / 125)
	localparam logic [9:0]  SUB_TOP     = 10'd1023;

	// first day of each month in a common year, day of year counted from 0
	localparam logic [8:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// remainder by seven: octal digits fold since 8 is 1 mod 7
	function automatic logic [2:0] mod7(input logic [15:0] x);
		logic [5:0] f1;
		logic [3:0] f2;
		logic [3:0] f3;
		f1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[15]);
		f2 = 4'(f1[2:0]) + 4'(f1[5:3]);
		f3 = 4'(f2[2:0]) + 4'(f2[3]);
		if (f3 >= 4'd7) begin
			f3 = f3 - 4'd7;
		end
		return f3[2:0];
	endfunction

endpackage

// File: rtl/core/epoch_ms_to_calendar.sv
// a taken beat passes through the stage registers s1 to s9 and leaves with done raised
// throughput: one beat every cycle, busy is never raised
// the result is held on the ports for one cycle only, the receiver cannot stall
// reset: arst_n clears every stage valid bit at once, data registers keep their value
module epoch_ms_to_calendar (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [emcal_pkg::MS_W-1:0]    epoch_ms,
	output logic                          done,
	output logic [emcal_pkg::YEAR_W-1:0]  year_of_century,
	output logic [emcal_pkg::MONTH_W-1:0] month,
	output logic [emcal_pkg::DOM_W-1:0]   day_of_month,
	output logic [emcal_pkg::WD_W-1:0]    weekday,
	output logic [emcal_pkg::HOUR_W-1:0]  hours,
	output logic [emcal_pkg::MIN_W-1:0]   minutes,
	output logic [emcal_pkg::SEC_W-1:0]   seconds,
	output logic [emcal_pkg::SUB_W-1:0]   subsecond_count,
	output logic                          out_of_range
);
	import emcal_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	// stage 1 data
	logic [31:0] q0_s1;
	logic [9:0]  lo_s1;
	logic [15:0] est_s1;
	// stage 2 data
	logic [9:0]  lo_s2;
	logic [15:0] est_s2;
	logic [17:0] r_s2;
	// stage 3 data
	logic [15:0] d_s3;
	logic        oor_s3;
	logic [26:0] msod_s3;
	// stage 4 data
	logic [15:0] d_s4;
	logic        oor_s4;
	logic [26:0] msod_s4;
	logic [4:0]  quad_s4;
	logic [16:0] sod_s4;
	logic [2:0]  wd_s4;
	// stage 5 data
	logic        oor_s5;
	logic [2:0]  wd_s5;
	logic [4:0]  quad_s5;
	logic [16:0] sod_s5;
	logic [11:0] rem_s5;
	logic [10:0] msp_s5;
	// stage 6 data
	logic        oor_s6;
	logic [2:0]  wd_s6;
	logic [4:0]  quad_s6;
	logic [10:0] rem_s6;
	logic [16:0] sod_s6;
	logic [9:0]  msp_s6;
	// stage 7 data
	logic        oor_s7;
	logic [2:0]  wd_s7;
	logic [6:0]  yr_s7;
	logic [8:0]  doy_s7;
	logic        leap_s7;
	logic [16:0] sod_s7;
	logic [10:0] mod_s7;
	logic [9:0]  sub_s7;
	// stage 8 data
	logic        oor_s8;
	logic [2:0]  wd_s8;
	logic [6:0]  yr_s8;
	logic [9:0]  sub_s8;
	logic [10:0] mod_s8;
	logic [3:0]  month_s8;
	logic [4:0]  day_s8;
	logic [5:0]  sec_s8;
	logic [4:0]  hrs_s8;
	// stage 9, the output register
	logic [YEAR_W-1:0]  year_s9;
	logic [MONTH_W-1:0] month_s9;
	logic [DOM_W-1:0]   day_s9;
	logic [WD_W-1:0]    wd_s9;
	logic [HOUR_W-1:0]  hrs_s9;
	logic [MIN_W-1:0]   min_s9;
	logic [SEC_W-1:0]   sec_s9;
	logic [SUB_W-1:0]   sub_s9;
	logic               oor_s9;

	// combinational terms
	logic        take;
	logic [47:0] day_prod;
	logic [32:0] r_prod;
	logic [32:0] r_diff;
	logic        day_fix;
	logic [15:0] days;
	logic [17:0] r_fixed;
	logic [26:0] quad_prod;
	logic [41:0] sod_prod;
	logic [15:0] rem_prod;
	logic [15:0] rem_diff;
	logic [26:0] msp_prod;
	logic [26:0] msp_diff;
	logic        quad_fix;
	logic        sec_fix;
	logic [10:0] yr_days;
	logic [1:0]  yr_in_quad;
	logic [8:0]  doy;
	logic        leap;
	logic [30:0] mod_prod;
	logic [26:0] sub_prod;
	logic [8:0]  mon_start;
	logic [8:0]  start_sel;
	logic [3:0]  mon;
	logic [8:0]  day_diff;
	logic [16:0] sec_prod;
	logic [16:0] sec_diff;
	logic [24:0] hrs_prod;
	logic [10:0] min_prod;
	logic [10:0] min_diff;

	// pipeline takes a beat in every cycle
	assign busy = 1'b0;
	assign take = start && !busy;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// stage 1: day estimate from ms / 1024 times a reciprocal, low by at most one
	assign day_prod = 48'(epoch_ms[41:10]) * 48'(DAY_RECIP);

	always_ff @(posedge clk) begin
		q0_s1  <= epoch_ms[41:10];
		lo_s1  <= epoch_ms[9:0];
		est_s1 <= day_prod[47:32];
	end

	// stage 2: remainder of the estimate
	assign r_prod = 33'(est_s1) * 33'(DAY_DIV);
	assign r_diff = 33'(q0_s1) - r_prod;

	always_ff @(posedge clk) begin
		lo_s2  <= lo_s1;
		est_s2 <= est_s1;
		r_s2   <= r_diff[17:0];
	end

	// stage 3: correct the day count, range check, rebuild ms of day
	assign day_fix = r_s2 >= 18'(DAY_DIV);
	assign days    = est_s2 + 16'(day_fix);
	assign r_fixed = day_fix ? r_s2 - 18'(DAY_DIV) : r_s2;

	always_ff @(posedge clk) begin
		d_s3    <= days - DAY_2000;
		oor_s3  <= (days < DAY_2000) || (days >= DAY_2100);
		msod_s3 <= {r_fixed[16:0], lo_s2};
	end

	// stage 4: four-year cycle and second-of-day estimates, weekday
	assign quad_prod = 27'(d_s3) * 27'(QUAD_RECIP);
	assign sod_prod  = 42'(msod_s3[26:3]) * 42'(SEC_RECIP);

	always_ff @(posedge clk) begin
		d_s4    <= d_s3;
		oor_s4  <= oor_s3;
		msod_s4 <= msod_s3;
		quad_s4 <= quad_prod[25:21];
		sod_s4  <= sod_prod[40:24];
		wd_s4   <= mod7(d_s3 + WEEK_OFS) + 3'd1;
	end

	// stage 5: remainders of both estimates
	assign rem_prod = 16'(quad_s4) * 16'(QUAD_DAYS);
	assign rem_diff = d_s4 - rem_prod;
	assign msp_prod = 27'(sod_s4) * 27'(MS_PER_SEC);
	assign msp_diff = msod_s4 - msp_prod;

	always_ff @(posedge clk) begin
		oor_s5  <= oor_s4;
		wd_s5   <= wd_s4;
		quad_s5 <= quad_s4;
		sod_s5  <= sod_s4;
		rem_s5  <= rem_diff[11:0];
		msp_s5  <= msp_diff[10:0];
	end

	// stage 6: correct cycle count and second of day
	assign quad_fix = rem_s5 >= 12'(QUAD_DAYS);
	assign sec_fix  = msp_s5 >= 11'(MS_PER_SEC);

	always_ff @(posedge clk) begin
		oor_s6  <= oor_s5;
		wd_s6   <= wd_s5;
		quad_s6 <= quad_s5 + 5'(quad_fix);
		rem_s6  <= quad_fix ? 11'(rem_s5 - 12'(QUAD_DAYS)) : rem_s5[10:0];
		sod_s6  <= sod_s5 + 17'(sec_fix);
		msp_s6  <= sec_fix ? 10'(msp_s5 - 11'(MS_PER_SEC)) : msp_s5[9:0];
	end

	// stage 7: year within the cycle, minute of day, sub-second value
	always_comb begin
		yr_days = rem_s6 - LEAP_YEAR_DAYS;
		if (rem_s6 < LEAP_YEAR_DAYS) begin
			yr_in_quad = 2'd0;
			doy        = rem_s6[8:0];
			leap       = 1'b1;
		end else if (yr_days >= TWO_YEAR_DAYS) begin
			yr_in_quad = 2'd3;
			doy        = 9'(yr_days - TWO_YEAR_DAYS);
			leap       = 1'b0;
		end else if (yr_days >= YEAR_DAYS) begin
			yr_in_quad = 2'd2;
			doy        = 9'(yr_days - YEAR_DAYS);
			leap       = 1'b0;
		end else begin
			yr_in_quad = 2'd1;
			doy        = yr_days[8:0];
			leap       = 1'b0;
		end
	end

	assign mod_prod = 31'(sod_s6[16:2]) * 31'(DIV15_RECIP);
	assign sub_prod = 27'(msp_s6) * 27'(SUB_RECIP);

	always_ff @(posedge clk) begin
		oor_s7  <= oor_s6;
		wd_s7   <= wd_s6;
		yr_s7   <= {quad_s6, yr_in_quad};
		doy_s7  <= doy;
		leap_s7 <= leap;
		sod_s7  <= sod_s6;
		mod_s7  <= mod_prod[29:19];
		sub_s7  <= SUB_TOP - sub_prod[25:16];
	end

	// stage 8: month search over the start table, seconds, hour estimate
	always_comb begin
		mon       = 4'd1;
		start_sel = 9'd0;
		mon_start = 9'd0;
		for (int k = 1; k < 12; k++) begin
			mon_start = MONTH_START[k] + ((k >= 2) ? 9'(leap_s7) : 9'd0);
			if (doy_s7 >= mon_start) begin
				mon       = 4'(k + 1);
				start_sel = mon_start;
			end
		end
	end

	assign day_diff = doy_s7 - start_sel + 9'd1;
	assign sec_prod = 17'(mod_s7) * 17'(SEC_PER_MIN);
	assign sec_diff = sod_s7 - sec_prod;
	assign hrs_prod = 25'(mod_s7[10:2]) * 25'(DIV15_RECIP);

	always_ff @(posedge clk) begin
		oor_s8   <= oor_s7;
		wd_s8    <= wd_s7;
		yr_s8    <= yr_s7;
		sub_s8   <= sub_s7;
		mod_s8   <= mod_s7;
		month_s8 <= mon;
		day_s8   <= day_diff[4:0];
		sec_s8   <= sec_diff[5:0];
		hrs_s8   <= hrs_prod[23:19];
	end

	// stage 9: minutes, then zero every field out of range
	assign min_prod = 11'(hrs_s8) * 11'(SEC_PER_MIN);
	assign min_diff = mod_s8 - min_prod;

	always_ff @(posedge clk) begin
		oor_s9   <= oor_s8;
		year_s9  <= oor_s8 ? '0 : yr_s8;
		month_s9 <= oor_s8 ? '0 : month_s8;
		day_s9   <= oor_s8 ? '0 : day_s8;
		wd_s9    <= oor_s8 ? '0 : wd_s8;
		hrs_s9   <= oor_s8 ? '0 : hrs_s8;
		min_s9   <= oor_s8 ? '0 : min_diff[5:0];
		sec_s9   <= oor_s8 ? '0 : sec_s8;
		sub_s9   <= oor_s8 ? '0 : sub_s8;
	end

	// result ports
	assign done            = v_s9;
	assign year_of_century = year_s9;
	assign month           = month_s9;
	assign day_of_month    = day_s9;
	assign weekday         = wd_s9;
	assign hours           = hrs_s9;
	assign minutes         = min_s9;
	assign seconds         = sec_s9;
	assign subsecond_count = sub_s9;
	assign out_of_range    = oor_s9;

endmodule

// File: rtl/core/emcal_check.sv
`include "epoch_ms_to_calendar_assert.svh"

module emcal_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [emcal_pkg::MS_W-1:0]    epoch_ms,
	input logic                          done,
	input logic [emcal_pkg::YEAR_W-1:0]  year_of_century,
	input logic [emcal_pkg::MONTH_W-1:0] month,
	input logic [emcal_pkg::DOM_W-1:0]   day_of_month,
	input logic [emcal_pkg::WD_W-1:0]    weekday,
	input logic [emcal_pkg::HOUR_W-1:0]  hours,
	input logic [emcal_pkg::MIN_W-1:0]   minutes,
	input logic [emcal_pkg::SEC_W-1:0]   seconds,
	input logic [emcal_pkg::SUB_W-1:0]   subsecond_count,
	input logic                          out_of_range
);
	import emcal_pkg::*;

	// every accepted beat comes out after the fixed latency
	`EMCAL_ASSERT_NOW(a_latency, start && !busy, ##9 done, "result missing after nine cycles")

	// no result without a matching beat taken at the input
	`EMCAL_ASSERT_NOW(a_no_spurious, done, $past(start && !busy, 9), "result without a beat")

	// times before the year 2000 are flagged
	`EMCAL_ASSERT_NOW(a_early_flag, start && !busy && (epoch_ms < 42'd946684800000), ##9 (done && out_of_range), "early time not flagged")

	// a flagged result carries only zero fields
	`EMCAL_ASSERT_NOW(a_zero_fields, done && out_of_range, (year_of_century == '0) && (month == '0) && (day_of_month == '0) && (weekday == '0) && (hours == '0) && (minutes == '0) && (seconds == '0) && (subsecond_count == '0), "flagged result not zero")

	// an in-range result lies inside the calendar
	`EMCAL_ASSERT_NOW(a_fields_legal, done && !out_of_range, (year_of_century < 7'd100) && (month >= 4'd1) && (month <= 4'd12) && (day_of_month != '0) && (weekday != '0) && (hours < 5'd24) && (minutes < 6'd60) && (seconds < 6'd60) && (subsecond_count != '0), "field out of calendar range")

endmodule

bind epoch_ms_to_calendar emcal_check u_emcal_check (.*);
